### hdl/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg
// Types, field widths and codes shared by the sorted key list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package skl_pkg;

    localparam int CMD_W            = 3;
    localparam int KEY_W            = 31;
    localparam int POS_W            = 5;
    localparam int STATUS_W         = 2;
    localparam int COUNT_W          = 5;
    localparam int DEPTH_DEF        = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT       = 3'd0,
        CMD_LOOKUP       = 3'd1,
        CMD_REMOVE_KEY   = 3'd2,
        CMD_READ_POS     = 3'd3,
        CMD_REMOVE_FIRST = 3'd4,
        CMD_REMOVE_LAST  = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_MISS  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_INSERT     = 2'd1,
        CELL_DELETE_GE  = 2'd2,
        CELL_DELETE_ALL = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [KEY_W-1:0] key;
        logic             pick_match;
        logic             pick_index;
    } skl_ctl_t;

endpackage

`default_nettype wire

### hdl/skl_cell.sv
// ----------------------------------------------------------------------------
// skl_cell
// One record slot of the sorted list: compares its key with the command key
// and takes a record from its left or right neighbor or from the command.
// ----------------------------------------------------------------------------
`default_nettype none

module skl_cell
    import skl_pkg::*;
#(
    parameter int IDX          = 0,
    parameter int FILL_W       = 5,
    parameter int IDX_W        = 4,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire skl_ctl_t                ctl,
    input  wire logic [PAYLOAD_BITS-1:0] new_payload,
    input  wire logic [FILL_W-1:0]       fill,
    input  wire logic [IDX_W-1:0]        target,
    input  wire logic [KEY_W-1:0]        left_key,
    input  wire logic [PAYLOAD_BITS-1:0] left_payload,
    input  wire logic                    left_lt,
    input  wire logic                    left_eq,
    input  wire logic [KEY_W-1:0]        right_key,
    input  wire logic [PAYLOAD_BITS-1:0] right_payload,
    output logic      [KEY_W-1:0]        key_out,
    output logic      [PAYLOAD_BITS-1:0] payload_out,
    output logic                         lt,
    output logic                         eq,
    output logic      [KEY_W-1:0]        pick_key,
    output logic      [PAYLOAD_BITS-1:0] pick_payload
);

    logic [KEY_W-1:0]        key_reg;
    logic [KEY_W-1:0]        key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] pay_next;
    logic                    occupied;
    logic                    pick;

    assign occupied = fill > FILL_W'(IDX);
    assign lt       = occupied && (key_reg < ctl.key);
    assign eq       = occupied && (key_reg == ctl.key);
    assign pick     = (ctl.pick_match && eq && !left_eq) ||
                      (ctl.pick_index && (target == IDX_W'(IDX)));

    assign key_out      = key_reg;
    assign payload_out  = pay_reg;
    assign pick_key     = pick ? key_reg : '0;
    assign pick_payload = pick ? pay_reg : '0;

    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        case (ctl.op)
            CELL_INSERT:
            begin
                if (!lt)
                begin
                    if (left_lt)
                    begin
                        key_next = ctl.key;
                        pay_next = new_payload;
                    end
                    else
                    begin
                        key_next = left_key;
                        pay_next = left_payload;
                    end
                end
            end
            CELL_DELETE_GE:
            begin
                if (key_reg >= ctl.key)
                begin
                    key_next = right_key;
                    pay_next = right_payload;
                end
            end
            CELL_DELETE_ALL:
            begin
                key_next = right_key;
                pay_next = right_payload;
            end
            default:
            begin
                key_next = key_reg;
                pay_next = pay_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

endmodule

`default_nettype wire

### hdl/sorted_key_list.sv
// ----------------------------------------------------------------------------
// sorted_key_list
// Bounded list of key/payload records kept in ascending key order in a row
// of cells; insert, lookup, remove by key, read by position, remove first/last.
// ----------------------------------------------------------------------------
// Output: the result item is registered and appears in the cycle after accept.
// Throughput: one item per cycle unless m_tready stalls the output; set by
// the combinational compare in every cell and the OR tree of picked records.
// Reset clears the record count and the output valid; cell contents are not
// reset and are never read before written.
`default_nettype none

module sorted_key_list
    import skl_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // cmd, key, payload, position (zero padded)
    input  wire logic [((CMD_W + KEY_W + PAYLOAD_BITS + POS_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status, found_key, found_payload, count (zero padded)
    output logic [((STATUS_W + KEY_W + PAYLOAD_BITS + COUNT_W + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_W   = ((STATUS_W + KEY_W + PAYLOAD_BITS + COUNT_W + 7) / 8) * 8;
    localparam int OUT_BITS = STATUS_W + KEY_W + PAYLOAD_BITS + COUNT_W;
    localparam int KEY_LO  = CMD_W;
    localparam int PAY_LO  = CMD_W + KEY_W;
    localparam int POS_LO  = CMD_W + KEY_W + PAYLOAD_BITS;
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W   = (FILL_W > POS_W) ? FILL_W : POS_W;

    logic [CMD_W-1:0]        in_cmd;
    logic [KEY_W-1:0]        in_key;
    logic [PAYLOAD_BITS-1:0] in_payload;
    logic [POS_W-1:0]        in_pos;
    logic                    accept;

    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_data_reg;
    logic [OUT_W-1:0]        m_data_next;

    skl_ctl_t                ctl;
    logic [IDX_W-1:0]        target;
    status_t                 status;
    logic                    found;
    logic                    full;
    logic                    empty;
    logic                    pos_ok;
    logic [CMP_W-1:0]        pos_ext;
    logic [CMP_W-1:0]        pos_m1;

    logic [KEY_W-1:0]        cell_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
    logic [KEY_W-1:0]        pick_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] pick_pay [DEPTH];
    logic [DEPTH-1:0]        cell_lt;
    logic [DEPTH-1:0]        cell_eq;
    logic [KEY_W-1:0]        rec_key;
    logic [PAYLOAD_BITS-1:0] rec_pay;

    assign in_cmd     = s_tdata[CMD_W-1:0];
    assign in_key     = s_tdata[KEY_LO +: KEY_W];
    assign in_payload = s_tdata[PAY_LO +: PAYLOAD_BITS];
    assign in_pos     = s_tdata[POS_LO +: POS_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign found   = |cell_eq;
    assign full    = fill_reg == FILL_W'(DEPTH);
    assign empty   = fill_reg == '0;
    assign pos_ext = CMP_W'(in_pos);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= CMP_W'(fill_reg));

    always_comb
    begin
        ctl.op         = CELL_HOLD;
        ctl.key        = in_key;
        ctl.pick_match = 1'b0;
        ctl.pick_index = 1'b0;
        target         = '0;
        status         = ST_MISS;
        fill_next      = fill_reg;
        case (in_cmd)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status    = ST_OK;
                    ctl.op    = CELL_INSERT;
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
            CMD_LOOKUP:
            begin
                ctl.pick_match = 1'b1;
                status         = found ? ST_OK : ST_MISS;
            end
            CMD_REMOVE_KEY:
            begin
                ctl.pick_match = 1'b1;
                if (found)
                begin
                    status    = ST_OK;
                    ctl.op    = CELL_DELETE_GE;
                    fill_next = fill_reg - FILL_W'(1);
                end
            end
            CMD_READ_POS:
            begin
                target = IDX_W'(pos_m1);
                if (pos_ok)
                begin
                    status         = ST_OK;
                    ctl.pick_index = 1'b1;
                end
            end
            CMD_REMOVE_FIRST:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    status         = ST_OK;
                    ctl.pick_index = 1'b1;
                    ctl.op         = CELL_DELETE_ALL;
                    fill_next      = fill_reg - FILL_W'(1);
                end
            end
            CMD_REMOVE_LAST:
            begin
                target = IDX_W'(fill_reg - FILL_W'(1));
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    status         = ST_OK;
                    ctl.pick_index = 1'b1;
                    fill_next      = fill_reg - FILL_W'(1);
                end
            end
            default:
            begin
                status = ST_MISS;
            end
        endcase
        if (!accept)
        begin
            ctl.op = CELL_HOLD;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [KEY_W-1:0]        l_key;
            logic [PAYLOAD_BITS-1:0] l_pay;
            logic                    l_lt;
            logic                    l_eq;
            logic [KEY_W-1:0]        r_key;
            logic [PAYLOAD_BITS-1:0] r_pay;

            if (gi == 0)
            begin : g_first
                assign l_key = '0;
                assign l_pay = '0;
                assign l_lt  = 1'b1;
                assign l_eq  = 1'b0;
            end
            else
            begin : g_mid
                assign l_key = cell_key[gi-1];
                assign l_pay = cell_pay[gi-1];
                assign l_lt  = cell_lt[gi-1];
                assign l_eq  = cell_eq[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign r_key = '0;
                assign r_pay = '0;
            end
            else
            begin : g_inner
                assign r_key = cell_key[gi+1];
                assign r_pay = cell_pay[gi+1];
            end

            skl_cell #(
                .IDX          (gi),
                .FILL_W       (FILL_W),
                .IDX_W        (IDX_W),
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk           (clk),
                .ctl           (ctl),
                .new_payload   (in_payload),
                .fill          (fill_reg),
                .target        (target),
                .left_key      (l_key),
                .left_payload  (l_pay),
                .left_lt       (l_lt),
                .left_eq       (l_eq),
                .right_key     (r_key),
                .right_payload (r_pay),
                .key_out       (cell_key[gi]),
                .payload_out   (cell_pay[gi]),
                .lt            (cell_lt[gi]),
                .eq            (cell_eq[gi]),
                .pick_key      (pick_key[gi]),
                .pick_payload  (pick_pay[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rec_key = '0;
        rec_pay = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rec_key = rec_key | pick_key[i];
            rec_pay = rec_pay | pick_pay[i];
        end
    end

    always_comb
    begin
        m_data_next = OUT_W'({COUNT_W'(fill_next), rec_pay, rec_key, status});
        if (OUT_W > OUT_BITS)
        begin
            m_data_next[OUT_W-1:OUT_BITS] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg    <= fill_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

`default_nettype wire
